@@ hw/rtl/scope_span_profiler_top_defines.svh @@
// ----------------------------------------------------------------------------
// scope span profiler assertion macros
// shared concurrent assertion forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef SCOPE_SPAN_PROFILER_TOP_DEFINES_SVH
`define SCOPE_SPAN_PROFILER_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define SSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define SSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ssp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_pkg
// types, sizes and codes shared by the scope span profiler
// ----------------------------------------------------------------------------
package ssp_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned NAME_COUNT  = 64;
  localparam int unsigned TIME_WIDTH  = 64;

  localparam int unsigned StkAw     = $clog2(STACK_DEPTH);
  localparam int unsigned LvlW      = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AggAw     = (NAME_COUNT > 1) ? $clog2(NAME_COUNT) : 1;
  localparam int unsigned NameW     = 6;
  localparam int unsigned ExcessW   = 8;
  localparam logic [ExcessW-1:0] ExcessMax = '1;

  typedef enum logic [1:0] {
    CMD_BEGIN     = 2'd0,
    CMD_END       = 2'd1,
    CMD_CLOSE_ALL = 2'd2,
    CMD_READ      = 2'd3
  } cmd_e;

  typedef enum logic {
    KIND_SPAN = 1'b0,
    KIND_AGG  = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_INCL,
    ST_POP_EXCL,
    ST_POP_UPD,
    ST_AGG_RD,
    ST_RESULT
  } eng_state_e;

  typedef logic [TIME_WIDTH-1:0] time_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [NameW-1:0] scope_name;
    logic [63:0]      timestamp;
  } in_word_t;

  typedef struct packed {
    logic             kind;
    logic [NameW-1:0] span_name;
    logic [63:0]      inclusive_time;
    logic [63:0]      exclusive_time;
    logic [3:0]       span_depth;
    logic [31:0]      call_count;
    logic [63:0]      total_inclusive;
    logic [63:0]      total_exclusive;
    logic [63:0]      min_inclusive;
    logic [63:0]      max_inclusive;
    logic [31:0]      unbalanced_count;
    logic             last;
  } out_word_t;

  typedef struct packed {
    logic [NameW-1:0] name;
    time_t            start;
  } stk_entry_t;

  typedef struct packed {
    logic [31:0] count;
    time_t       tot_incl;
    time_t       tot_excl;
    time_t       min_incl;
    time_t       max_incl;
  } agg_entry_t;

  typedef struct packed {
    logic             ent_we;
    logic [StkAw-1:0] ent_waddr;
    stk_entry_t       ent_wdata;
    logic             kids_we;
    logic [StkAw-1:0] kids_waddr;
    time_t            kids_wdata;
    logic             rd_en;
    logic [StkAw-1:0] ent_raddr;
    logic [StkAw-1:0] kids_raddr;
  } stk_req_t;

  typedef struct packed {
    logic             we;
    logic [AggAw-1:0] waddr;
    agg_entry_t       wdata;
    logic             rd_en;
    logic [AggAw-1:0] raddr;
  } agg_req_t;

  function automatic logic name_in_range(logic [NameW-1:0] n);
    return 32'(n) < NAME_COUNT;
  endfunction

  function automatic logic [AggAw-1:0] agg_index(logic [NameW-1:0] n);
    return AggAw'(n);
  endfunction

endpackage

@@ hw/rtl/scope_span_profiler_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scope_span_profiler_top
// scope begin/end profiler with an open scope stack and per-name aggregates
// ----------------------------------------------------------------------------
// begin: one word per cycle while the engine is idle, no result
// end: stack read, span math, aggregate read-modify-write, result stage and
//   output register; the input stalls until the result word is handed off
// read: aggregate read, then the result stage; the input stalls until handoff
// close all: one pop sequence per open scope, each ending in a result word
// reset: stack empty, counters zero, aggregate valid bits cleared at once
module scope_span_profiler_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ssp_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ssp_pkg::out_word_t out_word_o
);

  ssp_pkg::stk_req_t   stk_req;
  ssp_pkg::stk_entry_t stk_ent;
  ssp_pkg::time_t      stk_kids;
  ssp_pkg::agg_req_t   agg_req;
  ssp_pkg::agg_entry_t agg_rdata;
  logic                res_valid;
  logic                res_ready;
  ssp_pkg::out_word_t  res_word;
  logic                out_valid_q;
  ssp_pkg::out_word_t  out_word_q;

  ssp_stack_store u_stack (
    .clk_i        (clk_i),
    .req_i        (stk_req),
    .ent_rdata_o  (stk_ent),
    .kids_rdata_o (stk_kids)
  );

  ssp_agg_store u_agg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (agg_req),
    .rdata_o (agg_rdata)
  );

  ssp_span_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_word_i   (in_word_i),
    .in_stall_o  (in_stall_o),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_word_o  (res_word),
    .stk_req_o   (stk_req),
    .stk_ent_i   (stk_ent),
    .stk_kids_i  (stk_kids),
    .agg_req_o   (agg_req),
    .agg_rdata_i (agg_rdata)
  );

  // output register frees the engine as soon as a word moves out
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_word_q <= res_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

@@ hw/rtl/ssp_stack_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_stack_store
// open scope stack: name/start memory and child sum memory, registered reads
// ----------------------------------------------------------------------------
module ssp_stack_store (
  input  logic                clk_i,
  input  ssp_pkg::stk_req_t   req_i,
  output ssp_pkg::stk_entry_t ent_rdata_o,
  output ssp_pkg::time_t      kids_rdata_o
);

  ssp_pkg::stk_entry_t ent_mem_q  [ssp_pkg::STACK_DEPTH];
  ssp_pkg::time_t      kids_mem_q [ssp_pkg::STACK_DEPTH];
  ssp_pkg::stk_entry_t ent_rdata_q;
  ssp_pkg::time_t      kids_rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.ent_we) begin
      ent_mem_q[req_i.ent_waddr] <= req_i.ent_wdata;
    end
    if (req_i.rd_en) begin
      ent_rdata_q <= ent_mem_q[req_i.ent_raddr];
    end
  end

  // child sums of entries below the top; the top's own sum lives in the engine
  always_ff @(posedge clk_i) begin
    if (req_i.kids_we) begin
      kids_mem_q[req_i.kids_waddr] <= req_i.kids_wdata;
    end
    if (req_i.rd_en) begin
      kids_rdata_q <= kids_mem_q[req_i.kids_raddr];
    end
  end

  assign ent_rdata_o  = ent_rdata_q;
  assign kids_rdata_o = kids_rdata_q;

endmodule

@@ hw/rtl/ssp_agg_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_agg_store
// per-name aggregate memory with per-entry valid bits, registered read
// ----------------------------------------------------------------------------
module ssp_agg_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ssp_pkg::agg_req_t   req_i,
  output ssp_pkg::agg_entry_t rdata_o
);

  ssp_pkg::agg_entry_t            mem_q [ssp_pkg::NAME_COUNT];
  logic [ssp_pkg::NAME_COUNT-1:0] vld_q;
  ssp_pkg::agg_entry_t            rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.we) begin
      vld_q[req_i.waddr] <= 1'b1;
    end
  end

  // never-written entries read as all zero
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q <= vld_q[req_i.raddr] ? mem_q[req_i.raddr] : '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/ssp_span_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_span_engine
// command sequencer: stack push/pop, span math, aggregate read-modify-write
// ----------------------------------------------------------------------------
module ssp_span_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  ssp_pkg::in_word_t   in_word_i,
  output logic                in_stall_o,
  input  logic                res_ready_i,
  output logic                res_valid_o,
  output ssp_pkg::out_word_t  res_word_o,
  output ssp_pkg::stk_req_t   stk_req_o,
  input  ssp_pkg::stk_entry_t stk_ent_i,
  input  ssp_pkg::time_t      stk_kids_i,
  output ssp_pkg::agg_req_t   agg_req_o,
  input  ssp_pkg::agg_entry_t agg_rdata_i
);

  ssp_pkg::eng_state_e               state_q, state_d;
  logic [ssp_pkg::LvlW-1:0]          level_q, level_d;
  logic [ssp_pkg::ExcessW-1:0]       excess_q, excess_d;
  logic [31:0]                       unbal_q, unbal_d;
  ssp_pkg::time_t                    top_kids_q, top_kids_d;
  logic                              closing_q, closing_d;
  logic [ssp_pkg::NameW-1:0]         name_q, name_d;
  ssp_pkg::time_t                    t_q, t_d;
  ssp_pkg::time_t                    incl_q, incl_d;
  ssp_pkg::time_t                    excl_q, excl_d;
  ssp_pkg::time_t                    par_kids_q, par_kids_d;
  logic [ssp_pkg::StkAw-1:0]         depth_q, depth_d;
  logic                              name_ok_q, name_ok_d;
  logic                              aggr_q, aggr_d;
  ssp_pkg::out_word_t                res_q, res_d;

  ssp_pkg::cmd_e                     in_cmd;
  ssp_pkg::time_t                    in_t;
  logic                              stk_empty;
  logic                              stk_full;
  logic                              pop_go;
  logic                              ent_ok;
  logic [ssp_pkg::StkAw-1:0]         top_addr;
  logic [ssp_pkg::StkAw-1:0]         par_addr;
  logic [ssp_pkg::TIME_WIDTH:0]      kids_sum;
  ssp_pkg::agg_entry_t               agg_upd;

  assign in_cmd    = ssp_pkg::cmd_e'(in_word_i.cmd);
  assign in_t      = in_word_i.timestamp[ssp_pkg::TIME_WIDTH-1:0];
  assign stk_empty = (level_q == '0);
  assign stk_full  = (level_q == ssp_pkg::LvlW'(ssp_pkg::STACK_DEPTH));
  assign top_addr  = ssp_pkg::StkAw'(level_q - 1'b1);
  assign par_addr  = ssp_pkg::StkAw'(level_q - 2'd2);
  assign kids_sum  = {1'b0, par_kids_q} + {1'b0, incl_q};
  assign ent_ok    = ssp_pkg::name_in_range(stk_ent_i.name);

  // updated aggregate entry for the span being closed
  always_comb begin
    agg_upd          = agg_rdata_i;
    agg_upd.count    = agg_rdata_i.count + 32'd1;
    agg_upd.tot_incl = agg_rdata_i.tot_incl + incl_q;
    agg_upd.tot_excl = agg_rdata_i.tot_excl + excl_q;
    if (agg_rdata_i.count == '0) begin
      agg_upd.min_incl = incl_q;
      agg_upd.max_incl = incl_q;
    end else begin
      agg_upd.min_incl = (incl_q < agg_rdata_i.min_incl) ? incl_q : agg_rdata_i.min_incl;
      agg_upd.max_incl = (incl_q > agg_rdata_i.max_incl) ? incl_q : agg_rdata_i.max_incl;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q) inside
      ssp_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_cmd)
            ssp_pkg::CMD_END: begin
              if (excess_q == '0 && !stk_empty) state_d = ssp_pkg::ST_POP_INCL;
            end
            ssp_pkg::CMD_CLOSE_ALL: begin
              if (!stk_empty) state_d = ssp_pkg::ST_POP_INCL;
            end
            ssp_pkg::CMD_READ: state_d = ssp_pkg::ST_AGG_RD;
            default:           state_d = ssp_pkg::ST_IDLE;
          endcase
        end
      end
      ssp_pkg::ST_POP_INCL:                   state_d = ssp_pkg::ST_POP_EXCL;
      ssp_pkg::ST_POP_EXCL:                   state_d = ssp_pkg::ST_POP_UPD;
      ssp_pkg::ST_POP_UPD, ssp_pkg::ST_AGG_RD: state_d = ssp_pkg::ST_RESULT;
      ssp_pkg::ST_RESULT: begin
        if (res_ready_i) begin
          state_d = (closing_q && !stk_empty) ? ssp_pkg::ST_POP_INCL : ssp_pkg::ST_IDLE;
        end
      end
      default: state_d = ssp_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    level_d    = level_q;
    excess_d   = excess_q;
    unbal_d    = unbal_q;
    top_kids_d = top_kids_q;
    closing_d  = closing_q;
    name_d     = name_q;
    t_d        = t_q;
    incl_d     = incl_q;
    excl_d     = excl_q;
    par_kids_d = par_kids_q;
    depth_d    = depth_q;
    name_ok_d  = name_ok_q;
    aggr_d     = aggr_q;
    res_d      = res_q;
    pop_go     = 1'b0;

    stk_req_o                 = '0;
    stk_req_o.ent_waddr       = ssp_pkg::StkAw'(level_q);
    stk_req_o.ent_wdata.name  = in_word_i.scope_name;
    stk_req_o.ent_wdata.start = in_t;
    stk_req_o.kids_waddr      = top_addr;
    stk_req_o.kids_wdata      = top_kids_q;
    stk_req_o.ent_raddr       = top_addr;
    stk_req_o.kids_raddr      = par_addr;

    agg_req_o       = '0;
    agg_req_o.waddr = ssp_pkg::agg_index(name_q);
    agg_req_o.wdata = agg_upd;

    in_stall_o  = (state_q != ssp_pkg::ST_IDLE);
    res_valid_o = (state_q == ssp_pkg::ST_RESULT);
    res_word_o  = res_q;

    unique case (state_q)
      ssp_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          name_d    = in_word_i.scope_name;
          t_d       = in_t;
          closing_d = (in_cmd == ssp_pkg::CMD_CLOSE_ALL);
          unique case (in_cmd)
            ssp_pkg::CMD_BEGIN: begin
              if (!stk_full) begin
                stk_req_o.ent_we  = 1'b1;
                // park the current top's child sum before it stops being the top
                stk_req_o.kids_we = !stk_empty;
                top_kids_d        = '0;
                level_d           = level_q + 1'b1;
              end else if (excess_q != ssp_pkg::ExcessMax) begin
                excess_d = excess_q + 1'b1;
              end
            end
            ssp_pkg::CMD_END: begin
              if (excess_q != '0) begin
                excess_d = excess_q - 1'b1;
              end else if (stk_empty) begin
                unbal_d = unbal_q + 32'd1;
              end else begin
                pop_go = 1'b1;
              end
            end
            ssp_pkg::CMD_CLOSE_ALL: begin
              excess_d = '0;
              if (stk_empty) begin
                unbal_d = unbal_q + 32'(excess_q);
              end else begin
                unbal_d = unbal_q + 32'(excess_q) + 32'd1;
                pop_go  = 1'b1;
              end
            end
            ssp_pkg::CMD_READ: begin
              agg_req_o.rd_en = ssp_pkg::name_in_range(in_word_i.scope_name);
              agg_req_o.raddr = ssp_pkg::agg_index(in_word_i.scope_name);
            end
            default: begin
            end
          endcase
        end
      end
      ssp_pkg::ST_POP_INCL: begin
        name_d     = stk_ent_i.name;
        incl_d     = (t_q >= stk_ent_i.start) ? (t_q - stk_ent_i.start) : '0;
        par_kids_d = stk_kids_i;
        depth_d    = top_addr;
        level_d    = level_q - 1'b1;
        name_ok_d  = ent_ok;
        aggr_d     = ent_ok && (t_q != '0);
        agg_req_o.rd_en = ent_ok;
        agg_req_o.raddr = ssp_pkg::agg_index(stk_ent_i.name);
      end
      ssp_pkg::ST_POP_EXCL: begin
        excl_d = (incl_q >= top_kids_q) ? (incl_q - top_kids_q) : '0;
        // parent becomes the top; fold in this span, saturating
        if (!stk_empty) begin
          top_kids_d = kids_sum[ssp_pkg::TIME_WIDTH] ? '1 :
                       kids_sum[ssp_pkg::TIME_WIDTH-1:0];
        end
      end
      ssp_pkg::ST_POP_UPD: begin
        agg_req_o.we         = aggr_q;
        res_d                = '0;
        res_d.kind           = ssp_pkg::KIND_SPAN;
        res_d.span_name      = name_q;
        res_d.inclusive_time = 64'(incl_q);
        res_d.exclusive_time = 64'(excl_q);
        res_d.span_depth     = 4'(depth_q);
        if (aggr_q) begin
          res_d.call_count      = agg_upd.count;
          res_d.total_inclusive = 64'(agg_upd.tot_incl);
          res_d.total_exclusive = 64'(agg_upd.tot_excl);
          res_d.min_inclusive   = 64'(agg_upd.min_incl);
          res_d.max_inclusive   = 64'(agg_upd.max_incl);
        end else if (name_ok_q) begin
          res_d.call_count      = agg_rdata_i.count;
          res_d.total_inclusive = 64'(agg_rdata_i.tot_incl);
          res_d.total_exclusive = 64'(agg_rdata_i.tot_excl);
          res_d.min_inclusive   = 64'(agg_rdata_i.min_incl);
          res_d.max_inclusive   = 64'(agg_rdata_i.max_incl);
        end
        res_d.unbalanced_count = unbal_q;
        res_d.last             = !closing_q || stk_empty;
      end
      ssp_pkg::ST_AGG_RD: begin
        res_d           = '0;
        res_d.kind      = ssp_pkg::KIND_AGG;
        res_d.span_name = name_q;
        if (ssp_pkg::name_in_range(name_q)) begin
          res_d.call_count      = agg_rdata_i.count;
          res_d.total_inclusive = 64'(agg_rdata_i.tot_incl);
          res_d.total_exclusive = 64'(agg_rdata_i.tot_excl);
          res_d.min_inclusive   = 64'(agg_rdata_i.min_incl);
          res_d.max_inclusive   = 64'(agg_rdata_i.max_incl);
        end
        res_d.unbalanced_count = unbal_q;
        res_d.last             = 1'b1;
      end
      ssp_pkg::ST_RESULT: begin
        // close all keeps draining once the previous word is handed off
        if (res_ready_i && closing_q && !stk_empty) begin
          unbal_d = unbal_q + 32'd1;
          pop_go  = 1'b1;
        end
      end
      default: begin
      end
    endcase

    stk_req_o.rd_en = pop_go;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ssp_pkg::ST_IDLE;
      level_q    <= '0;
      excess_q   <= '0;
      unbal_q    <= '0;
      top_kids_q <= '0;
      closing_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      level_q    <= level_d;
      excess_q   <= excess_d;
      unbal_q    <= unbal_d;
      top_kids_q <= top_kids_d;
      closing_q  <= closing_d;
    end
  end

  always_ff @(posedge clk_i) begin
    name_q     <= name_d;
    t_q        <= t_d;
    incl_q     <= incl_d;
    excl_q     <= excl_d;
    par_kids_q <= par_kids_d;
    depth_q    <= depth_d;
    name_ok_q  <= name_ok_d;
    aggr_q     <= aggr_d;
    res_q      <= res_d;
  end

endmodule

@@ hw/rtl/ssp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_checker
// port-level checks for the scope span profiler, bound to the top level
// ----------------------------------------------------------------------------
`include "scope_span_profiler_top_defines.svh"

module ssp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_i,
  input ssp_pkg::in_word_t  in_word_i,
  input logic               out_valid_i,
  input logic               out_stall_i,
  input ssp_pkg::out_word_t out_word_i
);

  `SSP_ASSERT_NEXT(a_out_valid_held, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i, "stalled word dropped")
  `SSP_ASSERT_NEXT(a_out_word_held, clk_i, rst_ni, out_valid_i && out_stall_i, $stable(out_word_i), "stalled word changed")
  `SSP_ASSERT_NEXT(a_read_busy, clk_i, rst_ni, in_valid_i && !in_stall_i && in_word_i.cmd == ssp_pkg::CMD_READ, in_stall_i, "read accepted without going busy")
  `SSP_ASSERT_NOW(a_agg_word_shape, clk_i, rst_ni, out_valid_i && out_word_i.kind == ssp_pkg::KIND_AGG, out_word_i.last && out_word_i.inclusive_time == '0 && out_word_i.span_depth == '0, "bad aggregate read word")
  `SSP_ASSERT_NOW(a_excl_le_incl, clk_i, rst_ni, out_valid_i && out_word_i.kind == ssp_pkg::KIND_SPAN, out_word_i.exclusive_time <= out_word_i.inclusive_time, "exclusive above inclusive")

endmodule

bind scope_span_profiler_top ssp_checker u_ssp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_i  (out_word_o)
);

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the scope span profiler: a queue of scope words is
// driven under random gaps, every accepted word runs through an in-bench
// profile of the open stack and the per-name totals, and each report that
// leaves the block is checked against the oldest predicted report
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned    IDLE_LIMIT = 2000;
  localparam int unsigned    RAND_WORDS = 60;
  localparam ssp_pkg::time_t TIME_SAT   = '1;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  ssp_pkg::in_word_t  in_word   = '0;
  logic               in_stall;
  logic               out_valid;
  logic               out_stall = 1'b0;
  ssp_pkg::out_word_t out_word;

  scope_span_profiler_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // bench copy of the open scope stack and the name table
  logic [ssp_pkg::NameW-1:0]   open_nm   [ssp_pkg::STACK_DEPTH];
  ssp_pkg::time_t              open_t0   [ssp_pkg::STACK_DEPTH];
  ssp_pkg::time_t              open_kids [ssp_pkg::STACK_DEPTH];
  int unsigned                 open_level;
  logic [ssp_pkg::ExcessW-1:0] overflow_depth;
  logic [31:0]                 name_calls [ssp_pkg::NAME_COUNT];
  ssp_pkg::time_t              name_incl  [ssp_pkg::NAME_COUNT];
  ssp_pkg::time_t              name_excl  [ssp_pkg::NAME_COUNT];
  ssp_pkg::time_t              name_min   [ssp_pkg::NAME_COUNT];
  ssp_pkg::time_t              name_max   [ssp_pkg::NAME_COUNT];
  logic [31:0]                 unbal_total;

  ssp_pkg::in_word_t  pending_q [$];
  ssp_pkg::out_word_t report_q  [$];
  int unsigned        mismatches = 0;

  function automatic ssp_pkg::out_word_t with_totals(ssp_pkg::out_word_t r,
                                                     logic [ssp_pkg::NameW-1:0] nm);
    r.span_name = nm;
    if (nm < ssp_pkg::NAME_COUNT) begin
      r.call_count      = name_calls[nm];
      r.total_inclusive = name_incl[nm];
      r.total_exclusive = name_excl[nm];
      r.min_inclusive   = name_min[nm];
      r.max_inclusive   = name_max[nm];
    end
    r.unbalanced_count = unbal_total;
    return r;
  endfunction

  task automatic close_span(ssp_pkg::time_t t, logic is_last);
    int unsigned               idx;
    logic [ssp_pkg::NameW-1:0] nm;
    ssp_pkg::time_t            incl;
    ssp_pkg::time_t            excl;
    ssp_pkg::time_t            room;
    ssp_pkg::out_word_t        r;
    idx  = open_level - 1;
    nm   = open_nm[idx];
    incl = (t >= open_t0[idx]) ? t - open_t0[idx] : '0;
    excl = (incl >= open_kids[idx]) ? incl - open_kids[idx] : '0;
    open_level = idx;
    if (idx > 0) begin
      // parent child sum saturates
      room = TIME_SAT - open_kids[idx-1];
      open_kids[idx-1] = (incl > room) ? TIME_SAT : open_kids[idx-1] + incl;
    end
    if (t != '0 && nm < ssp_pkg::NAME_COUNT) begin
      if (name_calls[nm] == '0) begin
        name_min[nm] = incl;
        name_max[nm] = incl;
      end else begin
        if (incl < name_min[nm]) name_min[nm] = incl;
        if (incl > name_max[nm]) name_max[nm] = incl;
      end
      name_calls[nm] = name_calls[nm] + 32'd1;
      name_incl[nm]  = name_incl[nm] + incl;
      name_excl[nm]  = name_excl[nm] + excl;
    end
    r = '0;
    r.kind           = ssp_pkg::KIND_SPAN;
    r.inclusive_time = incl;
    r.exclusive_time = excl;
    r.span_depth     = 4'(idx);
    r = with_totals(r, nm);
    r.last = is_last;
    report_q = {report_q, r};
  endtask

  task automatic profile_word(ssp_pkg::in_word_t w);
    ssp_pkg::time_t     t;
    ssp_pkg::out_word_t r;
    t = ssp_pkg::time_t'(w.timestamp);
    case (ssp_pkg::cmd_e'(w.cmd))
      ssp_pkg::CMD_BEGIN: begin
        if (open_level < ssp_pkg::STACK_DEPTH) begin
          open_nm[open_level]   = w.scope_name;
          open_t0[open_level]   = t;
          open_kids[open_level] = '0;
          open_level++;
        end else if (overflow_depth != ssp_pkg::ExcessMax) begin
          overflow_depth++;
        end
      end
      ssp_pkg::CMD_END: begin
        if (overflow_depth != '0) overflow_depth--;
        else if (open_level == 0) unbal_total = unbal_total + 32'd1;
        else close_span(t, 1'b1);
      end
      ssp_pkg::CMD_CLOSE_ALL: begin
        unbal_total    = unbal_total + 32'(overflow_depth);
        overflow_depth = '0;
        while (open_level > 0) begin
          unbal_total = unbal_total + 32'd1;
          close_span(t, open_level == 1);
        end
      end
      default: begin
        r      = '0;
        r.kind = ssp_pkg::KIND_AGG;
        r      = with_totals(r, w.scope_name);
        r.last = 1'b1;
        report_q = {report_q, r};
      end
    endcase
  endtask

  task automatic check_report(ssp_pkg::out_word_t got);
    ssp_pkg::out_word_t want;
    string              diff;
    if (report_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected report: %p", got);
      return;
    end
    want = report_q.pop_front();
    diff = "";
    if (got.kind !== want.kind)
      diff = {diff, $sformatf(" kind %0d/%0d", want.kind, got.kind)};
    if (got.span_name !== want.span_name)
      diff = {diff, $sformatf(" name %0d/%0d", want.span_name, got.span_name)};
    if (got.inclusive_time !== want.inclusive_time)
      diff = {diff, $sformatf(" incl %h/%h", want.inclusive_time, got.inclusive_time)};
    if (got.exclusive_time !== want.exclusive_time)
      diff = {diff, $sformatf(" excl %h/%h", want.exclusive_time, got.exclusive_time)};
    if (got.span_depth !== want.span_depth)
      diff = {diff, $sformatf(" depth %0d/%0d", want.span_depth, got.span_depth)};
    if (got.call_count !== want.call_count)
      diff = {diff, $sformatf(" calls %0d/%0d", want.call_count, got.call_count)};
    if (got.total_inclusive !== want.total_inclusive)
      diff = {diff, $sformatf(" tot_incl %h/%h", want.total_inclusive, got.total_inclusive)};
    if (got.total_exclusive !== want.total_exclusive)
      diff = {diff, $sformatf(" tot_excl %h/%h", want.total_exclusive, got.total_exclusive)};
    if (got.min_inclusive !== want.min_inclusive)
      diff = {diff, $sformatf(" min %h/%h", want.min_inclusive, got.min_inclusive)};
    if (got.max_inclusive !== want.max_inclusive)
      diff = {diff, $sformatf(" max %h/%h", want.max_inclusive, got.max_inclusive)};
    if (got.unbalanced_count !== want.unbalanced_count)
      diff = {diff, $sformatf(" unbal %0d/%0d", want.unbalanced_count, got.unbalanced_count)};
    if (got.last !== want.last)
      diff = {diff, $sformatf(" last %0d/%0d", want.last, got.last)};
    if (diff != "") begin
      mismatches++;
      if (mismatches <= 10) $display("report mismatch (expected/actual):%s", diff);
    end
  endtask

  task automatic queue_word(ssp_pkg::cmd_e c, logic [ssp_pkg::NameW-1:0] nm,
                            logic [63:0] t);
    ssp_pkg::in_word_t w;
    w.cmd        = c;
    w.scope_name = nm;
    w.timestamp  = t;
    pending_q = {pending_q, w};
  endtask

  function automatic logic [63:0] rand_time64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ssp_pkg::NameW-1:0] pick_name();
    // a small pool so totals build up per name
    if ($urandom_range(0, 3) != 0) return ssp_pkg::NameW'($urandom_range(0, 7));
    return ssp_pkg::NameW'($urandom_range(0, 63));
  endfunction

  function automatic logic [63:0] time_step();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) return '0;
    if (roll < 75) return 64'($urandom_range(1, 1000));
    if (roll < 95) return 64'($urandom);
    return rand_time64();
  endfunction

  // input driver
  always @(posedge clk or negedge rst_n) begin : drive
    logic        hold;
    int unsigned in_gap;
    logic        steady_in;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_word   <= '0;
      in_gap    = 0;
      steady_in = 1'b0;
    end else begin
      hold = in_valid && in_stall;
      if (in_valid && !in_stall) begin
        profile_word(in_word);
        if ($urandom_range(0, 39) == 0) steady_in = ~steady_in;
        in_gap = steady_in ? 0 : $urandom_range(0, 3);
      end
      if (hold) begin
        // stalled word stays as it is
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        in_valid <= 1'b1;
        in_word  <= pending_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk or negedge rst_n) begin : watch
    int unsigned stall_left;
    logic        steady_out;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
      steady_out = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_report(out_word);
        if ($urandom_range(0, 29) == 0) steady_out = ~steady_out;
        stall_left = steady_out ? 0 : $urandom_range(0, 3);
      end else if (out_valid && stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(negedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("[scope_span_profiler_top] ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned target;
    int unsigned run_len;
    int unsigned roll;
    int unsigned depth_guess;
    int unsigned base;
    logic [63:0] cursor;

    open_level     = 0;
    overflow_depth = '0;
    unbal_total    = '0;
    for (int i = 0; i < ssp_pkg::NAME_COUNT; i++) begin
      name_calls[i] = '0;
      name_incl[i]  = '0;
      name_excl[i]  = '0;
      name_min[i]   = '0;
      name_max[i]   = '0;
    end

    // directed words
    queue_word(ssp_pkg::CMD_END, 6'd0, 64'd7);          // end with nothing open
    queue_word(ssp_pkg::CMD_READ, 6'd0, '0);            // untouched name reads zero
    queue_word(ssp_pkg::CMD_BEGIN, 6'd63, '0);
    queue_word(ssp_pkg::CMD_END, 6'd21, '0);            // span ending at time zero
    queue_word(ssp_pkg::CMD_READ, 6'd63, '1);
    queue_word(ssp_pkg::CMD_BEGIN, 6'd1, '0);
    queue_word(ssp_pkg::CMD_BEGIN, 6'd2, '0);
    queue_word(ssp_pkg::CMD_END, 6'd0, '1);
    queue_word(ssp_pkg::CMD_BEGIN, 6'd3, '0);
    queue_word(ssp_pkg::CMD_END, 6'd0, '1);             // parent child sum saturates
    queue_word(ssp_pkg::CMD_END, 6'd0, 64'd5);          // exclusive floors at zero
    queue_word(ssp_pkg::CMD_BEGIN, 6'd4, 64'd100);
    queue_word(ssp_pkg::CMD_END, 6'd0, 64'd50);         // time ran backwards
    queue_word(ssp_pkg::CMD_BEGIN, 6'd2, 64'd1000);
    queue_word(ssp_pkg::CMD_END, 6'd0, 64'd1003);       // new minimum for name 2
    queue_word(ssp_pkg::CMD_READ, 6'd1, '0);
    queue_word(ssp_pkg::CMD_READ, 6'd2, '0);
    queue_word(ssp_pkg::CMD_READ, 6'd3, '0);
    queue_word(ssp_pkg::CMD_READ, 6'd4, '0);
    queue_word(ssp_pkg::CMD_CLOSE_ALL, 6'd0, 64'd60);   // nothing open
    queue_word(ssp_pkg::CMD_BEGIN, 6'd5, 64'd10);
    queue_word(ssp_pkg::CMD_BEGIN, 6'd6, 64'd20);
    queue_word(ssp_pkg::CMD_CLOSE_ALL, 6'd0, 64'd30);
    queue_word(ssp_pkg::CMD_READ, 6'd5, '0);

    // overfill the stack until the overflow count saturates
    cursor = 64'd5000;
    repeat (ssp_pkg::STACK_DEPTH + 256) begin
      cursor = cursor + 64'($urandom_range(0, 50));
      queue_word(ssp_pkg::CMD_BEGIN, pick_name(), cursor);
    end
    repeat (3) queue_word(ssp_pkg::CMD_END, 6'd0, cursor);
    queue_word(ssp_pkg::CMD_CLOSE_ALL, 6'd0, cursor + 64'd9);
    queue_word(ssp_pkg::CMD_READ, pick_name(), '0);

    // random sessions: mostly nested begin/end runs, some noise
    base = pending_q.size();
    while (pending_q.size() < base + RAND_WORDS) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) target = $urandom_range(1, 6);
      else if (roll < 90) target = $urandom_range(7, ssp_pkg::STACK_DEPTH);
      else target = $urandom_range(ssp_pkg::STACK_DEPTH + 1, ssp_pkg::STACK_DEPTH + 4);
      run_len = $urandom_range(6, 40);
      roll = $urandom_range(0, 9);
      if (roll < 3) cursor = '0;
      else if (roll < 9) cursor = 64'($urandom);
      else cursor = {32'hffff_ffff, $urandom};
      depth_guess = 0;
      repeat (run_len) begin
        roll   = $urandom_range(0, 99);
        cursor = cursor + time_step();
        if (roll < 8) begin
          queue_word(ssp_pkg::cmd_e'($urandom_range(0, 3)),
                     ssp_pkg::NameW'($urandom_range(0, 63)), rand_time64());
        end else if (roll < 16) begin
          queue_word(ssp_pkg::CMD_READ, pick_name(), rand_time64());
        end else if (depth_guess < target && (roll < 60 || depth_guess == 0)) begin
          queue_word(ssp_pkg::CMD_BEGIN, pick_name(), cursor);
          depth_guess++;
        end else begin
          queue_word(ssp_pkg::CMD_END, ssp_pkg::NameW'($urandom_range(0, 63)), cursor);
          if (depth_guess > 0) depth_guess--;
        end
      end
      cursor = cursor + time_step();
      if ($urandom_range(0, 1) == 0) begin
        queue_word(ssp_pkg::CMD_CLOSE_ALL, ssp_pkg::NameW'($urandom_range(0, 63)), cursor);
      end else begin
        repeat (depth_guess) queue_word(ssp_pkg::CMD_END, pick_name(), cursor);
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (pending_q.size() != 0 || in_valid || report_q.size() != 0);
    repeat (20) @(negedge clk);

    if (mismatches == 0 && report_q.size() == 0) begin
      $display("[scope_span_profiler_top] OK");
    end else begin
      $display("[scope_span_profiler_top] ERROR");
    end
    $finish;
  end

endmodule
